@@ rtl/mbd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and register codes for the mask boundary detector.
// ----------------------------------------------------------------------------
package mbd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MASK_WIDTH  = 2'd0;
	localparam logic [1:0] REG_MASK_HEIGHT = 2'd1;

	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [10:0] MASK_WIDTH_RST  = 11'd512;
	localparam logic [12:0] MASK_HEIGHT_RST = 13'd512;

	// load request from the window stage to the output buffer
	typedef struct packed {
		logic load;   // a result (or pair) is presented
		logic pair;   // second result follows the first
	} load_req_t;

endpackage

@@ rtl/mbd_line_store.sv @@
// ----------------------------------------------------------------------------
// mbd_line_store
// Two-bit line memory {row two above, row above}, read at x and x+1 with
// registered data and a bypass for a write landing on the same edge.
// ----------------------------------------------------------------------------
module mbd_line_store #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_c,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_r,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [1:0]               wr_data,
	output logic [1:0]               center_pair,
	output logic                     right_above
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rd_c_q;
	logic       rd_r_q;
	logic       fwd_c_q;
	logic       fwd_r_q;
	logic [1:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_c_q     <= mem[rd_addr_c];
			rd_r_q     <= mem[rd_addr_r][0];
			fwd_c_q    <= wr_en && (wr_addr == rd_addr_c);
			fwd_r_q    <= wr_en && (wr_addr == rd_addr_r);
			fwd_data_q <= wr_data;
		end
	end

	assign center_pair = fwd_c_q ? fwd_data_q : rd_c_q;
	assign right_above = fwd_r_q ? fwd_data_q[0] : rd_r_q;

endmodule

@@ rtl/mbd_out_stage.sv @@
// ----------------------------------------------------------------------------
// mbd_out_stage
// Output register plus one pending slot, so a pixel that yields two
// results is drained over two transactions.
// ----------------------------------------------------------------------------
module mbd_out_stage #(
	parameter int PW = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mbd_pkg::load_req_t req,
	input  logic [PW-1:0]     first_data,
	input  logic [PW-1:0]     second_data,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PW-1:0]     out_data
);

	logic          out_valid_q;
	logic [PW-1:0] out_q;
	logic          pend_valid_q;
	logic [PW-1:0] pend_q;
	logic          taken;

	assign taken    = out_valid_q && !out_stall;
	assign can_load = !out_valid_q || (taken && !pend_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (req.load && can_load) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= req.pair;
		end else if (taken) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load && can_load) begin
			out_q  <= first_data;
			pend_q <= second_data;
		end else if (taken) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/mask_boundary_detector.sv @@
// ----------------------------------------------------------------------------
// mask_boundary_detector
// 4-neighbour boundary marking of a binary mask streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one mask bit per transaction (in_valid / in_stall),
//    row 0 first, column 0 first within a row.
//  - Output channel: pixel_col, pixel_row, is_edge, last_of_run per
//    transaction (out_valid / out_stall). Pixel (x,y-1) is reported when
//    (x,y) arrives; on the bottom row (x,y) follows it with last_of_run set.
//    Top-row pixels of a multi-row slice produce nothing.
//  - Config: cfg_wr_en / cfg_index / cfg_data, written while idle; any write
//    to mask_width or mask_height restarts the frame at pixel (0,0).
//  - Path: line-store read and window register at the accepting edge, then
//    the output register.
//  - Throughput: one pixel per cycle while the receiver does not stall;
//    bottom-row pixels of a multi-row slice are slower, since every one
//    yields two output transactions through the single output register.
//  - Receiver stall: the output register and its pending slot hold, then the
//    window stage holds and in_stall rises; nothing is dropped.
//  - Reset: counters and handshake state clear at once; line stores are not
//    cleared (entries are always written before the frame reads them).
// ----------------------------------------------------------------------------
module mask_boundary_detector #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [mbd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// pixel input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mask_bit,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [$clog2(MAX_WIDTH)-1:0]        pixel_col,
	output logic [$clog2(MAX_HEIGHT)-1:0]       pixel_row,
	output logic                                is_edge,
	output logic                                last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CH = $clog2(MAX_HEIGHT);
	localparam int WL = CW + 1;   // holds MAX_WIDTH itself
	localparam int HL = CH + 1;
	localparam int PW = CW + CH + 2;

	// clamp a register value into 1..limit
	function automatic logic [WL-1:0] eff_width(input logic [10:0] v);
		logic [31:0] vv;
		vv = 32'(v);
		if (vv == 32'd0)
			return WL'(1);
		if (vv > 32'(MAX_WIDTH))
			return WL'(MAX_WIDTH);
		return WL'(vv);
	endfunction

	function automatic logic [HL-1:0] eff_height(input logic [12:0] v);
		logic [31:0] vv;
		vv = 32'(v);
		if (vv == 32'd0)
			return HL'(1);
		if (vv > 32'(MAX_HEIGHT))
			return HL'(MAX_HEIGHT);
		return HL'(vv);
	endfunction

	// effective frame size
	logic [WL-1:0] w_q;
	logic [HL-1:0] h_q;

	// raster position of the next input pixel
	logic [CW-1:0] col_q;
	logic [CH-1:0] row_q;
	logic          left_q;   // old row-above bit of the column to the left

	// window stage
	logic          valid_s1;
	logic          bit_s1;
	logic [CW-1:0] x_s1;
	logic [CH-1:0] y_s1;
	logic          bottom_s1;
	logic          last_col_s1;

	logic          accept;
	logic          adv_s1;
	logic          out_ready;

	// ---------------------------------------------------------------- position
	logic [CW-1:0] x_c;
	logic [CH-1:0] y_c;
	logic          bottom_c;
	logic          last_col_c;

	always_comb begin
		x_c        = ({1'b0, col_q} >= w_q) ? CW'(w_q - WL'(1)) : col_q;
		y_c        = ({1'b0, row_q} >= h_q) ? CH'(h_q - HL'(1)) : row_q;
		bottom_c   = ({1'b0, row_q} + HL'(1)) >= h_q;
		last_col_c = ({1'b0, x_c} + WL'(1)) >= w_q;
	end

	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= eff_width(mbd_pkg::MASK_WIDTH_RST);
			h_q   <= eff_height(mbd_pkg::MASK_HEIGHT_RST);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == mbd_pkg::REG_MASK_WIDTH) begin
				w_q   <= eff_width(cfg_data[10:0]);
				col_q <= '0;
				row_q <= '0;
			end else if (cfg_index == mbd_pkg::REG_MASK_HEIGHT) begin
				h_q   <= eff_height(cfg_data);
				col_q <= '0;
				row_q <= '0;
			end
		end else if (accept) begin
			if (last_col_c) begin
				col_q <= '0;
				row_q <= bottom_c ? '0 : CH'({1'b0, y_c} + HL'(1));
			end else begin
				col_q <= CW'({1'b0, x_c} + WL'(1));
			end
		end
	end

	// ---------------------------------------------------------------- line store
	logic [1:0] center_pair;
	logic       right_raw;

	mbd_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk        (clk),
		.rd_en      (accept),
		.rd_addr_c  (x_c),
		.rd_addr_r  (CW'({1'b0, x_c} + WL'(1))),
		.wr_en      (adv_s1),
		.wr_addr    (x_s1),
		.wr_data    ({center_pair[0], bit_s1}),
		.center_pair(center_pair),
		.right_above(right_raw)
	);

	// ---------------------------------------------------------------- window stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_s1      <= mask_bit;
			x_s1        <= x_c;
			y_s1        <= y_c;
			bottom_s1   <= bottom_c;
			last_col_s1 <= last_col_c;
		end
	end

	// left neighbour tracks the previous pixel's center; cleared at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 1'b0;
		end else if (cfg_wr_en && (cfg_index == mbd_pkg::REG_MASK_WIDTH ||
		                          cfg_index == mbd_pkg::REG_MASK_HEIGHT)) begin
			left_q <= 1'b0;
		end else if (adv_s1) begin
			left_q <= last_col_s1 ? 1'b0 : center_pair[0];
		end
	end

	logic               center;
	logic               up;
	logic               right;
	logic               has_up;
	logic               edge_flag;
	mbd_pkg::load_req_t req;
	logic [PW-1:0]      res_up;
	logic [PW-1:0]      res_self;
	logic [PW-1:0]      first_data;

	always_comb begin
		center    = center_pair[0];
		up        = center_pair[1];
		right     = last_col_s1 ? 1'b0 : right_raw;
		has_up    = (y_s1 != '0);
		// set pixel with any clear neighbour or touching the border
		edge_flag = center && ((x_s1 == '0) || !left_q || last_col_s1 || !right ||
		                       (y_s1 == CH'(1)) || !up || !bit_s1);
		res_up    = {x_s1, CH'(y_s1 - CH'(1)), edge_flag, !bottom_s1};
		res_self  = {x_s1, y_s1, bit_s1, 1'b1};
		first_data = has_up ? res_up : res_self;
		req.load  = valid_s1 && (has_up || bottom_s1);
		req.pair  = has_up && bottom_s1;
		// top-row pixels of a tall slice leave without a result
		adv_s1    = valid_s1 && (!(has_up || bottom_s1) || out_ready);
	end

	// ---------------------------------------------------------------- output
	logic [PW-1:0] out_data;

	mbd_out_stage #(
		.PW(PW)
	) u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.first_data (first_data),
		.second_data(res_self),
		.can_load   (out_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	assign pixel_col   = out_data[PW-1 -: CW];
	assign pixel_row   = out_data[CH+1:2];
	assign is_edge     = out_data[1];
	assign last_of_run = out_data[0];

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stand-alone bench for mask_boundary_detector: a short directed table
// (reset state, single-row and zero sizes, small frames), then extreme
// frame shapes and random small frames, checked against typed results
// or a behavioral boundary tracker, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 4096;
	localparam int SETTLE     = 6;     // pipeline is two deep; a few spare
	localparam int QUIET_MAX  = 4000;  // cycles with no transaction at all
	localparam int RAND_ITEMS = 500;

	// one reported pixel
	typedef struct packed {
		logic [9:0]  col;
		logic [11:0] row;
		logic        edge_bit;
		logic        last;
	} px_result_t;

	typedef enum logic {ST_PIXEL, ST_WRITE} stim_op_t;

	// directed row: n_exp < 0 means "ask the tracker", otherwise the
	// expected result count is typed in (0 or 1, with exp_r for 1)
	typedef struct {
		stim_op_t        op;
		logic [1:0]      idx;
		logic [12:0]     data;
		logic            pix;
		int              n_exp;
		px_result_t      exp_r;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        mask_bit;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  pixel_col;
	logic [11:0] pixel_row;
	logic        is_edge;
	logic        last_of_run;

	mask_boundary_detector #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mask_bit   (mask_bit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.is_edge    (is_edge),
		.last_of_run(last_of_run)
	);

	// ------------------------------------------------------------------------
	// Boundary tracker state: its own copy of the line stores, window and
	// position counters, plus the two size registers.
	// ------------------------------------------------------------------------
	logic        lb_above [MAX_W];
	logic        lb_two   [MAX_W];
	logic        left_c;
	int          col_cnt;
	int          row_cnt;
	logic [10:0] width_q;
	logic [12:0] height_q;

	px_result_t  pending_px [$];   // results still owed by the block
	int          err_count    = 0;
	int          items_sent   = 0;
	int          results_seen = 0;
	int          phase_count  = 0;
	int          quiet_cycles = 0;

	// Directed table. Typed rows are the ones that need no thought: the
	// first pixels after reset (top row, nothing out) and single-row slices
	// where each pixel comes straight back with its own bit as edge flag.
	stim_row_t directed [28] = '{
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, 0,  '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b0, 0,  '0},
		'{ST_WRITE, mbd_pkg::REG_MASK_HEIGHT, 13'd1, 1'b0, 0,  '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, 1,  {10'd0, 12'd0, 1'b1, 1'b1}},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b0, 1,  {10'd1, 12'd0, 1'b0, 1'b1}},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, 1,  {10'd2, 12'd0, 1'b1, 1'b1}},
		// zero width behaves as one column
		'{ST_WRITE, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b0, 0,  '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, 1,  {10'd0, 12'd0, 1'b1, 1'b1}},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b0, 1,  {10'd0, 12'd0, 1'b0, 1'b1}},
		// zero height behaves as one row
		'{ST_WRITE, mbd_pkg::REG_MASK_HEIGHT, 13'd0, 1'b0, 0,  '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, 1,  {10'd0, 12'd0, 1'b1, 1'b1}},
		// 3x3 frame: top row silent, middle row single, bottom row pairs
		'{ST_WRITE, mbd_pkg::REG_MASK_WIDTH,  13'd3, 1'b0, 0,  '0},
		'{ST_WRITE, mbd_pkg::REG_MASK_HEIGHT, 13'd3, 1'b0, 0,  '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b0, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b0, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		// 2x2 solid: every set pixel sits on the border
		'{ST_WRITE, mbd_pkg::REG_MASK_WIDTH,  13'd2, 1'b0, 0,  '0},
		'{ST_WRITE, mbd_pkg::REG_MASK_HEIGHT, 13'd2, 1'b0, 0,  '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0},
		'{ST_PIXEL, mbd_pkg::REG_MASK_WIDTH,  13'd0, 1'b1, -1, '0}
	};

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Idle profile: three stretches of 220 pixels each.
	// Mode 0: sender 29%, receiver 45%. Mode 1: swapped. Mode 2: no idling.
	// ------------------------------------------------------------------------
	function automatic int tx_idle_pct();
		case ((items_sent / 220) % 3)
			0: return 29;
			1: return 45;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct();
		case ((items_sent / 220) % 3)
			0: return 45;
			1: return 29;
			default: return 0;
		endcase
	endfunction

	// zero acts as one, oversize clamps to the parameter
	function automatic int eff_dim(input int v, input int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Boundary tracker: consumes one mask bit, returns how many pixels the
	// block reports for it (0..2) in r0 / r1, and advances its own window.
	// ------------------------------------------------------------------------
	function automatic int boundary_step(input logic pix, output px_result_t r0,
			output px_result_t r1);
		int         w, h, x, y, n;
		logic       bottom, center, up, right, e;
		px_result_t r;
		w      = eff_dim(int'(width_q), MAX_W);
		h      = eff_dim(int'(height_q), MAX_H);
		x      = col_cnt;
		y      = row_cnt;
		bottom = (y + 1 >= h);
		n      = 0;
		r0     = '0;
		r1     = '0;
		if (x >= w)
			x = w - 1;
		if (y >= h)
			y = h - 1;
		center = lb_above[x];

		// pixel above the incoming one now has all four neighbours
		if (y >= 1) begin
			up    = lb_two[x];
			right = (x + 1 < w) ? lb_above[x + 1] : 1'b0;
			e     = 1'b0;
			if (center) begin
				if (x == 0 || !left_c)
					e = 1'b1;
				if (x + 1 >= w || !right)
					e = 1'b1;
				if (y == 1 || !up)   // upper row consulted only below row 0
					e = 1'b1;
				if (!pix)
					e = 1'b1;
			end
			r0 = '{col: 10'(x), row: 12'(y - 1), edge_bit: e, last: !bottom};
			n  = 1;
		end
		// bottom row pixel is on the border: edge flag is its own bit
		if (bottom) begin
			r = '{col: 10'(x), row: 12'(y), edge_bit: pix, last: 1'b1};
			if (n == 0)
				r0 = r;
			else
				r1 = r;
			n++;
		end

		left_c    = center;
		lb_two[x] = center;
		lb_above[x] = pix;
		if (x + 1 >= w) begin
			col_cnt = 0;
			left_c  = 1'b0;
			row_cnt = bottom ? 0 : y + 1;
		end else begin
			col_cnt = x + 1;
			row_cnt = y;
		end
		return n;
	endfunction

	// ------------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("tb: mismatch at result %0d: %s got %0d want %0d",
			results_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Drop valid and wait until every owed result is in.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_px.size() != 0);
	endtask

	// Register write, only with the block idle. A top-row pixel owes no
	// result, so after draining let the pipeline empty out before writing.
	task automatic write_reg(input logic [1:0] idx, input logic [12:0] d);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == mbd_pkg::REG_MASK_WIDTH)
			width_q = d[10:0];
		else if (idx == mbd_pkg::REG_MASK_HEIGHT)
			height_q = d;
		// any write restarts the frame
		col_cnt = 0;
		row_cnt = 0;
		left_c  = 1'b0;
	endtask

	// One pixel transaction. Values read right after the edge are the
	// pre-edge ones, so "!in_stall" here means the block took it.
	task automatic send_pixel(input logic pix, input int n_typed, input px_result_t typed_r);
		px_result_t r0, r1;
		int         n;
		while ($urandom_range(0, 99) < tx_idle_pct()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mask_bit <= pix;
		do
			@(posedge clk);
		while (in_stall);
		n = boundary_step(pix, r0, r1);
		if (n_typed < 0) begin
			if (n > 0)
				pending_px.push_back(r0);
			if (n > 1)
				pending_px.push_back(r1);
		end else if (n_typed == 1) begin
			pending_px.push_back(typed_r);
		end
		items_sent++;
	endtask

	// One phase: set both sizes, then stream n_px pixels. The content is
	// either random noise at a random density or a solid rectangle with a
	// little noise, which gives real interior/boundary structure.
	task automatic stream_phase(input logic [12:0] wd, input logic [12:0] hd, input int n_px);
		int   we, he, style, dens, x0, x1, y0, y1, xi, yi, i;
		logic pix;
		write_reg(mbd_pkg::REG_MASK_WIDTH, wd);
		write_reg(mbd_pkg::REG_MASK_HEIGHT, hd);
		phase_count++;
		we    = eff_dim(int'(wd[10:0]), MAX_W);
		he    = eff_dim(int'(hd), MAX_H);
		style = $urandom_range(0, 1);
		case ($urandom_range(0, 3))
			0: dens = 5;
			1: dens = 50;
			2: dens = 85;
			default: dens = 100;
		endcase
		x0 = $urandom_range(0, we - 1);
		x1 = $urandom_range(x0, we - 1);
		y0 = $urandom_range(0, he - 1);
		y1 = $urandom_range(y0, he - 1);
		for (i = 0; i < n_px; i++) begin
			xi = i % we;
			yi = (i / we) % he;
			if (style == 0)
				pix = ($urandom_range(0, 99) < dens);
			else
				pix = (xi >= x0 && xi <= x1 && yi >= y0 && yi <= y1)
					^ ($urandom_range(0, 99) < 5);
			send_pixel(pix, -1, '0);
			// now and then hold the sender until the block has caught up
			if (items_sent % 128 == 0)
				wait_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: random stall, and the result checker.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct());
	end

	always @(posedge clk) begin
		px_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_px.size() == 0) begin
				report_mismatch("unexpected result, pixel_col", int'(pixel_col), -1);
			end else begin
				want = pending_px.pop_front();
				if (pixel_col !== want.col)
					report_mismatch("pixel_col", int'(pixel_col), int'(want.col));
				if (pixel_row !== want.row)
					report_mismatch("pixel_row", int'(pixel_row), int'(want.row));
				if (is_edge !== want.edge_bit)
					report_mismatch("is_edge", int'(is_edge), int'(want.edge_bit));
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
			end
			results_seen++;
		end
	end

	// Watchdog: any transaction on either side resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("tb: watchdog expired with %0d results owed", pending_px.size());
			$display("tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int i, base;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= mbd_pkg::REG_MASK_WIDTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		mask_bit  <= 1'b0;
		for (i = 0; i < MAX_W; i++) begin
			lb_above[i] = 1'b0;
			lb_two[i]   = 1'b0;
		end
		left_c   = 1'b0;
		col_cnt  = 0;
		row_cnt  = 0;
		width_q  = mbd_pkg::MASK_WIDTH_RST;
		height_q = mbd_pkg::MASK_HEIGHT_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < $size(directed); i++) begin
			if (directed[i].op == ST_WRITE)
				write_reg(directed[i].idx, directed[i].data);
			else
				send_pixel(directed[i].pix, directed[i].n_exp, directed[i].exp_r);
		end

		// extremes: full width on a single row, oversize height on one
		// column, oversize width on a single row
		stream_phase(13'd1024, 13'd1, 40);
		stream_phase(13'd1, 13'h1FFF, 40);
		stream_phase(13'h1FFF, 13'd1, 40);

		// random small frames; some phases stop mid-frame and restart
		base = items_sent;
		while (items_sent - base < RAND_ITEMS) begin
			int ws, hs, n;
			ws = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
			hs = $urandom_range(1, 12);
			n  = ws * hs * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, ws * hs);
			if (n > RAND_ITEMS - (items_sent - base))
				n = RAND_ITEMS - (items_sent - base);
			stream_phase(13'(ws), 13'(hs), n);
		end

		// drain, let the pipeline settle, then judge
		wait_drained();
		repeat (SETTLE * 2) @(posedge clk);
		if (pending_px.size() != 0)
			report_mismatch("results never delivered", 0, pending_px.size());

		$display("tb: %0d pixels in %0d size phases, %0d results compared",
			items_sent, phase_count, results_seen);
		$display("tb: sizes from 1x1 to full width, clamped oversize, restarts mid-frame");
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mbd_pkg.sv
rtl/mbd_line_store.sv
rtl/mbd_out_stage.sv
rtl/mask_boundary_detector.sv
sim/tb.sv
